// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and character helpers for the PDF string escaper.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM = 1'b1;

  localparam logic [1:0] MODE_LITERAL = 2'd0;
  localparam logic [1:0] MODE_NAME    = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;
  localparam logic [1:0] MODE_UNHEX   = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // one queued run of up to four results caused by one input item
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            data;
    logic            ovf;
    logic            send;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else begin
      r = 5'h00;
    end
    return r;
  endfunction

  function automatic logic name_delim(input logic [7:0] c);
    return c == 8'd35 || c == 8'd37 || c == 8'd40 || c == 8'd41 || c == 8'd47 ||
           c == 8'd60 || c == 8'd62 || c == 8'd91 || c == 8'd93 || c == 8'd123 ||
           c == 8'd125;
  endfunction

endpackage

// ===== rtl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front
// Accepts input bytes, checks output room, classifies and expands each byte
// into a run of results, and keeps the per-string state and registers.
// ----------------------------------------------------------------------------
module pse_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  input  logic                           q_full,
  output logic                           q_push,
  output pse_pkg::job_t                  q_job
);

  logic [1:0]  mode_r;
  logic [15:0] out_room_r;
  logic [15:0] out_count_r, out_count_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic        pend_r, pend_nxt;
  logic        drop_r, drop_nxt;

  logic        accept;
  logic [2:0]  need;
  logic        room_hit;
  logic [2:0]  n;
  logic [4:0]  hv;
  pse_pkg::job_t job;

  assign accept = push && !q_full;
  assign hv     = pse_pkg::hex_value(in_byte);

  always_comb begin
    case (mode_r)
      pse_pkg::MODE_LITERAL: need = 3'd4;
      pse_pkg::MODE_NAME:    need = 3'd3;
      pse_pkg::MODE_HEX:     need = 3'd2;
      default:               need = 3'd1;
    endcase
  end

  assign room_hit = ({1'b0, out_count_r} + {14'b0, need}) >= {1'b0, out_room_r};

  always_comb begin
    job           = '0;
    n             = 3'd0;
    out_count_nxt = out_count_r;
    hn_nxt        = hn_r;
    pend_nxt      = pend_r;
    drop_nxt      = drop_r;
    if (drop_r) begin
      if (in_last) begin
        job.ovf = 1'b1;
        n       = 3'd1;
      end
    end else if (room_hit) begin
      drop_nxt = 1'b1;
      job.ovf  = 1'b1;
      n        = 3'd1;
    end else begin
      job.data = 1'b1;
      case (mode_r)
        pse_pkg::MODE_LITERAL: begin
          if (in_byte < pse_pkg::CH_BANG || in_byte > pse_pkg::CH_TILDE) begin
            job.bytes[0] = pse_pkg::CH_BSLASH;
            job.bytes[1] = pse_pkg::CH_ZERO + {6'h0, in_byte[7:6]};
            job.bytes[2] = pse_pkg::CH_ZERO + {5'h0, in_byte[5:3]};
            job.bytes[3] = pse_pkg::CH_ZERO + {5'h0, in_byte[2:0]};
            n = 3'd4;
          end else if (in_byte == pse_pkg::CH_LPAREN || in_byte == pse_pkg::CH_RPAREN ||
                       in_byte == pse_pkg::CH_BSLASH) begin
            job.bytes[0] = pse_pkg::CH_BSLASH;
            job.bytes[1] = in_byte;
            n = 3'd2;
          end else begin
            job.bytes[0] = in_byte;
            n = 3'd1;
          end
        end
        pse_pkg::MODE_NAME: begin
          if (in_byte == 8'h00) begin
            n = 3'd0;
          end else if (in_byte <= 8'd32 || in_byte >= pse_pkg::CH_DEL ||
                       pse_pkg::name_delim(in_byte)) begin
            job.bytes[0] = pse_pkg::CH_HASH;
            job.bytes[1] = pse_pkg::hex_char(in_byte[7:4]);
            job.bytes[2] = pse_pkg::hex_char(in_byte[3:0]);
            n = 3'd3;
          end else begin
            job.bytes[0] = in_byte;
            n = 3'd1;
          end
        end
        pse_pkg::MODE_HEX: begin
          job.bytes[0] = pse_pkg::hex_char(in_byte[7:4]);
          job.bytes[1] = pse_pkg::hex_char(in_byte[3:0]);
          n = 3'd2;
        end
        default: begin
          if (hv[4]) begin
            if (pend_r) begin
              job.bytes[0] = {hn_r, hv[3:0]};
              n            = 3'd1;
              pend_nxt     = 1'b0;
            end else begin
              hn_nxt   = hv[3:0];
              pend_nxt = 1'b1;
            end
          end
          if (in_last && pend_nxt) begin
            job.bytes[0] = {hn_nxt, 4'h0};
            n            = 3'd1;
            pend_nxt     = 1'b0;
          end
        end
      endcase
      if (n != 3'd0) begin
        out_count_nxt = out_count_r + {13'h0, n};
      end else if (in_last) begin
        job.data = 1'b0;
        n        = 3'd1;
      end
    end
    job.send     = in_last;
    job.last_idx = 2'(n - 3'd1);
    if (in_last) begin
      out_count_nxt = '0;
      hn_nxt        = '0;
      pend_nxt      = 1'b0;
      drop_nxt      = 1'b0;
    end
  end

  assign q_push = accept && (n != 3'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= pse_pkg::MODE_LITERAL;
      out_room_r  <= 16'hFFFF;
      out_count_r <= '0;
      hn_r        <= '0;
      pend_r      <= 1'b0;
      drop_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pse_pkg::REG_MODE: mode_r     <= cfg_data[1:0];
          pse_pkg::REG_ROOM: out_room_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        out_count_r <= out_count_nxt;
        hn_r        <= hn_nxt;
        pend_r      <= pend_nxt;
        drop_r      <= drop_nxt;
      end
    end
  end

endmodule

// ===== rtl/pse_fifo.sv =====
// ----------------------------------------------------------------------------
// pse_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pse_fifo #(
  parameter int unsigned DEPTH = pse_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  pse_pkg::job_t wr_job,
  input  logic          rd,
  output pse_pkg::job_t rd_job,
  output logic          q_full,
  output logic          q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pse_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = cnt_r == CNT_W'(DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = slots[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_empty || q_full) |-> (wp_r == rp_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back
// Walks each queued job one result per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module pse_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pse_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_run_last,
  output logic          out_string_end,
  output logic          out_overflow
);

  logic [1:0] k_r;
  logic       ov_r;
  logic [7:0] byte_r;
  logic       bv_r, rl_r, se_r, of_r;
  logic       load;
  logic       at_end;

  assign load   = !q_empty && (!ov_r || pop);
  assign at_end = k_r == q_job.last_idx;
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        k_r  <= at_end ? 2'd0 : k_r + 2'd1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_job.bytes[k_r];
      bv_r   <= q_job.data;
      rl_r   <= at_end;
      se_r   <= q_job.send;
      of_r   <= q_job.ovf;
    end
  end

  assign empty          = !ov_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_run_last   = rl_r;
  assign out_string_end = se_r;
  assign out_overflow   = of_r;

  a_marker_single: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !bv_r) |-> (rl_r && byte_r == 8'h00))
    else $error("marker result not alone in its run");

  a_ovf_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && of_r) |-> !bv_r)
    else $error("overflow flagged on a data result");

  a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (k_r == 2'd0))
    else $error("result index not rewound after run");

endmodule

// ===== rtl/pdf_string_escape.sv =====
// The first result of an item goes into the job queue, then into the output register.
// Throughput: one input item per cycle while the job queue has room; results leave
// at one per cycle while pop is high; each item yields 0 to 4 results.
// Results drain at one per cycle while pop is high, which sets the sustained rate.
// Reset (rst_n low, synchronous): mode = literal, out_room = 65535, string state
// and queue cleared, no result pending.
// ----------------------------------------------------------------------------
// pdf_string_escape
// PDF string escaper: literal, name, hex and unhex conversion of byte streams.
// ----------------------------------------------------------------------------
module pdf_string_escape #(
  parameter int unsigned QUEUE_DEPTH = pse_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_run_last,
  output logic                           out_string_end,
  output logic                           out_overflow
);

  pse_pkg::job_t wr_job, rd_job;
  logic          q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  pse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (wr_job)
  );

  pse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_job  (wr_job),
    .rd      (q_pop),
    .rd_job  (rd_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  pse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (rd_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_overflow   (out_overflow)
  );

endmodule

// ===== tb/pdf_string_escape_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdf_string_escape_tb
// Drives byte strings through all four escape modes under random room limits,
// predicts every emitted result in the bench and checks each output transfer.
// ----------------------------------------------------------------------------
module pdf_string_escape_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // characters the stimulus favors outside unhex mode
  localparam logic [7:0] HOT_CHARS [18] = '{
    8'h00, 8'h20, 8'h21, 8'h7E, 8'h7F, 8'hFF, 8'h23, 8'h25, 8'h28,
    8'h29, 8'h2F, 8'h3C, 8'h3E, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D
  };

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       str_end;
    logic       ovf;
  } esc_result_t;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index = pse_pkg::REG_MODE;
  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           push      = 1'b0;
  logic                           full;
  logic [7:0]                     in_byte   = 8'h00;
  logic                           in_last   = 1'b0;
  logic                           empty;
  logic                           pop       = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_byte_valid;
  logic                           out_run_last;
  logic                           out_string_end;
  logic                           out_overflow;

  // bench copy of block state
  logic [1:0]  cur_mode  = pse_pkg::MODE_LITERAL;
  logic [15:0] cur_room  = 16'hFFFF;
  logic [15:0] emit_cnt  = '0;
  logic [3:0]  nib_hi    = '0;
  logic        nib_pend  = 1'b0;
  logic        cutting   = 1'b0;

  esc_result_t escaped_q[$];
  esc_result_t item_run[$];

  int    errors     = 0;
  int    items_sent = 0;
  int    hold_len   = 0;
  int    cycle_cnt  = 0;
  bit    no_idle    = 1'b0;

  pdf_string_escape dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL pdf_string_escape");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
  endfunction

  function automatic logic is_name_delim(input logic [7:0] c);
    case (c)
      8'd35, 8'd37, 8'd40, 8'd41, 8'd47, 8'd60, 8'd62, 8'd91, 8'd93, 8'd123,
      8'd125: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_char(input logic [1:0] m);
    int v;
    if (m == pse_pkg::MODE_UNHEX && $urandom_range(0, 4) != 0) begin
      v = $urandom_range(0, 21);
      if (v < 10) return 8'(8'h30 + v);
      if (v < 16) return 8'(8'h41 + v - 10);
      return 8'(8'h61 + v - 16);
    end
    if ($urandom_range(0, 1) == 0) return HOT_CHARS[$urandom_range(0, 17)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_result(input logic [7:0] b, input logic valid, input logic ovf);
    item_run.push_back('{data: b, valid: valid, run_last: 1'b0, str_end: 1'b0, ovf: ovf});
    if (valid) emit_cnt = emit_cnt + 16'd1;
  endtask

  // expected results for one accepted string byte
  task automatic escape_byte(input logic [7:0] c, input logic last);
    int         need;
    logic [3:0] nib;
    bit         is_hex;
    item_run.delete();
    case (cur_mode)
      pse_pkg::MODE_LITERAL: need = 4;
      pse_pkg::MODE_NAME:    need = 3;
      pse_pkg::MODE_HEX:     need = 2;
      default:               need = 1;
    endcase
    if (cutting) begin
      if (last) add_result(8'h00, 1'b0, 1'b1);
    end else if (32'(emit_cnt) + need >= 32'(cur_room)) begin
      cutting = 1'b1;
      add_result(8'h00, 1'b0, 1'b1);
    end else begin
      case (cur_mode)
        pse_pkg::MODE_LITERAL: begin
          if (c < pse_pkg::CH_BANG || c > pse_pkg::CH_TILDE) begin
            add_result(pse_pkg::CH_BSLASH, 1'b1, 1'b0);
            add_result(pse_pkg::CH_ZERO + {6'd0, c[7:6]}, 1'b1, 1'b0);
            add_result(pse_pkg::CH_ZERO + {5'd0, c[5:3]}, 1'b1, 1'b0);
            add_result(pse_pkg::CH_ZERO + {5'd0, c[2:0]}, 1'b1, 1'b0);
          end else begin
            if (c == pse_pkg::CH_LPAREN || c == pse_pkg::CH_RPAREN ||
                c == pse_pkg::CH_BSLASH)
              add_result(pse_pkg::CH_BSLASH, 1'b1, 1'b0);
            add_result(c, 1'b1, 1'b0);
          end
        end
        pse_pkg::MODE_NAME: begin
          if (c != 8'h00) begin
            if (c <= 8'h20 || c >= pse_pkg::CH_DEL || is_name_delim(c)) begin
              add_result(pse_pkg::CH_HASH, 1'b1, 1'b0);
              add_result(hex_digit(c[7:4]), 1'b1, 1'b0);
              add_result(hex_digit(c[3:0]), 1'b1, 1'b0);
            end else begin
              add_result(c, 1'b1, 1'b0);
            end
          end
        end
        pse_pkg::MODE_HEX: begin
          add_result(hex_digit(c[7:4]), 1'b1, 1'b0);
          add_result(hex_digit(c[3:0]), 1'b1, 1'b0);
        end
        default: begin
          is_hex = 1'b1;
          nib    = 4'h0;
          if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
          else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
          else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
          else is_hex = 1'b0;
          if (is_hex) begin
            if (nib_pend) begin
              add_result({nib_hi, nib}, 1'b1, 1'b0);
              nib_pend = 1'b0;
            end else begin
              nib_hi   = nib;
              nib_pend = 1'b1;
            end
          end
          // odd digit count: flush the saved high nibble
          if (last && nib_pend) begin
            add_result({nib_hi, 4'h0}, 1'b1, 1'b0);
            nib_pend = 1'b0;
          end
        end
      endcase
      if (last && item_run.size() == 0) add_result(8'h00, 1'b0, 1'b0);
    end
    foreach (item_run[i]) begin
      item_run[i].run_last = (i == item_run.size() - 1);
      item_run[i].str_end  = last;
      escaped_q.push_back(item_run[i]);
    end
    if (last) begin
      emit_cnt = '0;
      nib_hi   = '0;
      nib_pend = 1'b0;
      cutting  = 1'b0;
    end
  endtask

  // result side: check each transfer, then decide pop for the next edge
  always @(posedge clk) begin : result_side
    esc_result_t got;
    esc_result_t want;
    int          stall_cnt;
    int          hold_cnt;
    if (rst_n && pop && !empty) begin
      got = {out_byte, out_byte_valid, out_run_last, out_string_end, out_overflow};
      if (escaped_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, %s%02h valid=%b last=%b end=%b ovf=%b",
                 $time, "actual byte=", got.data, got.valid, got.run_last, got.str_end,
                 got.ovf);
      end else begin
        want = escaped_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected byte=%02h valid=%b last=%b end=%b ovf=%b,",
                   $time, want.data, want.valid, want.run_last, want.str_end, want.ovf);
          $display("%0t:           actual byte=%02h valid=%b last=%b end=%b ovf=%b",
                   $time, got.data, got.valid, got.run_last, got.str_end, got.ovf);
        end
      end
    end
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!no_idle) stall_cnt = rand_gap();
    end
  end

  // one input transfer; returns at the accepting edge with push still high
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : rand_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    escape_byte(b, last);
    items_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$], input bit close);
    foreach (s[i]) send_byte(s[i], close && i == s.size() - 1);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input logic [15:0] room);
    cfg_we    <= 1'b1;
    cfg_index <= pse_pkg::REG_MODE;
    cfg_data  <= {14'($urandom_range(0, 16383)), m};
    @(posedge clk);
    cur_mode   = m;
    cfg_index <= pse_pkg::REG_ROOM;
    cfg_data  <= room;
    @(posedge clk);
    cur_room = room;
    cfg_we  <= 1'b0;
  endtask

  task automatic test_literal();
    logic [7:0] s[$];
    wait_idle();
    configure(pse_pkg::MODE_LITERAL, 16'hFFFF);
    s = {8'h00, 8'h20, pse_pkg::CH_BANG, pse_pkg::CH_LPAREN, pse_pkg::CH_BSLASH,
         pse_pkg::CH_TILDE, pse_pkg::CH_DEL, 8'hFF};
    send_string(s, 1'b1);
  endtask

  task automatic test_name();
    logic [7:0] s[$];
    wait_idle();
    configure(pse_pkg::MODE_NAME, 16'hFFFF);
    // a trailing zero byte yields only the end marker
    s = {8'h00, pse_pkg::CH_HASH, pse_pkg::CH_TILDE, pse_pkg::CH_DEL, 8'h20, 8'h00};
    send_string(s, 1'b1);
  endtask

  task automatic test_hex();
    logic [7:0] s[$];
    wait_idle();
    configure(pse_pkg::MODE_HEX, 16'hFFFF);
    s = {8'h00, 8'hFF};
    send_string(s, 1'b1);
  endtask

  task automatic test_unhex();
    logic [7:0] s[$];
    wait_idle();
    configure(pse_pkg::MODE_UNHEX, 16'hFFFF);
    s = {8'h61, 8'h46, 8'h78, 8'h31};
    send_string(s, 1'b1);
    s = {8'h7A};
    send_string(s, 1'b1);
  endtask

  task automatic test_overflow();
    logic [7:0] s[$];
    wait_idle();
    configure(pse_pkg::MODE_LITERAL, 16'h0000);
    s = {8'h78, 8'h79};
    send_string(s, 1'b1);
    wait_idle();
    configure(pse_pkg::MODE_LITERAL, 16'd6);
    s = {8'h41, 8'h00, 8'h00, 8'h41};
    send_string(s, 1'b1);
  endtask

  // result side holds off while items keep coming, then the sender waits for all
  task automatic test_backpressure();
    wait_idle();
    configure(pse_pkg::MODE_HEX, 16'hFFFF);
    no_idle  = 1'b1;
    hold_len = 80;
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(0, 255)), i == 23);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random(input int target);
    int          base;
    int          phase;
    int          phase_end;
    int          len;
    bit          open;
    logic [1:0]  m;
    logic [15:0] room;
    base  = items_sent;
    phase = 0;
    while (items_sent - base < target) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      m = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       room = 16'h0000;
        1:       room = 16'hFFFF;
        2, 3:    room = 16'($urandom_range(1, 40));
        4:       room = 16'($urandom_range(41, 300));
        default: room = 16'($urandom_range(0, 65535));
      endcase
      if (phase == 4) room = 16'h0001;
      if (phase == 5) room = 16'hFFFF;
      configure(m, room);
      phase_end = items_sent + $urandom_range(20, 40);
      while (items_sent < phase_end) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        // sometimes the string stays open across the next register update
        open = (items_sent + len >= phase_end) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) send_byte(pick_char(m), !open && i == len - 1);
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_literal();
    test_name();
    test_hex();
    test_unhex();
    test_overflow();
    test_backpressure();
    test_random(370);
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS pdf_string_escape");
    end else begin
      $display("FAIL pdf_string_escape");
    end
    $finish;
  end

endmodule
